FILE: rtl/lfa_pkg.sv
// Package for the toroidal Life automaton: sizes, register indexes, types and state codes.
package lfa_pkg;

    localparam int COLUMNS = 16;
    localparam int ROWS    = 8;
    localparam int COL_W   = 4;    // column index width
    localparam int CNT_W   = 16;   // detection counter width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int ACC_W   = 9;    // signed population accumulator
    localparam int SEED_FIRST = 4;
    localparam int SEED_LAST  = 11;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAME_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_MASK    = 3'd4;

    // register reset values
    localparam logic [7:0] DEAD_LIMIT_RST   = 8'd4;
    localparam logic [7:0] SAME_LIMIT_RST   = 8'd8;
    localparam logic [7:0] STABLE_LIMIT_RST = 8'd40;
    localparam logic [9:0] CYCLE_LIMIT_RST  = 10'd240;
    localparam logic [7:0] SEED_MASK_RST    = 8'b0111_1100;

    // input kinds
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef logic [ROWS-1:0] col_t;
    typedef col_t [COLUMNS-1:0] frame_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DECIDE,
        ST_GEN,
        ST_LIVE,
        ST_DONE
    } state_t;

    // sequencer controls toward the datapath
    typedef struct packed {
        logic ready;
        logic load_frame;
        logic step_start;
        logic count_en;
        logic decide;
        logic gen_en;
        logic live_en;
        logic acc_clr;
        logic out_load;
    } ctl_t;

endpackage

FILE: rtl/lfa_next_col.sv
// Life rule B3/S23 for one column of cells from its left, own and right columns.
module lfa_next_col
    import lfa_pkg::*;
(
    input  col_t left,
    input  col_t mid,
    input  col_t right,
    output col_t next_col
);

    // per row neighbor count with vertical wraparound
    always_comb
    begin
        logic [3:0] n;
        int         up;
        int         dn;
        next_col = '0;
        for (int y = 0; y < ROWS; y++)
        begin
            up = (y + ROWS - 1) % ROWS;
            dn = (y + 1) % ROWS;
            n = 4'(left[up]) + 4'(left[y]) + 4'(left[dn])
              + 4'(mid[up]) + 4'(mid[dn])
              + 4'(right[up]) + 4'(right[y]) + 4'(right[dn]);
            next_col[y] = (n == 4'd3) || (n == 4'd2 && mid[y]);
        end
    end

endmodule

FILE: rtl/lfa_pop_acc.sv
// Shared population unit: accumulates pop(a) - pop(b) over a column scan.
module lfa_pop_acc
    import lfa_pkg::*;
(
    input  logic                    clk,
    input  logic                    clr,
    input  logic                    en,
    input  col_t                    a,
    input  col_t                    b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    function automatic logic [3:0] pop8(input col_t v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    // one add and subtract per cycle while en is high
    always_comb
    begin
        acc_next = acc_reg;
        if (clr)
        begin
            acc_next = '0;
        end
        else if (en)
        begin
            acc_next = acc_reg + $signed({5'd0, pop8(a)}) - $signed({5'd0, pop8(b)});
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/lfa_ctrl.sv
// Sequencer: column scans for counting, generation and population.
module lfa_ctrl
    import lfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_cmd,
    input  logic out_free,
    output ctl_t ctl
);

    state_t           state_reg;
    state_t           state_next;
    logic [COL_W-1:0] cnt_reg;
    logic [COL_W-1:0] cnt_next;
    logic             last_col;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    assign last_col = (cnt_reg == LAST_COL);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_cmd == CMD_LOAD) ? ST_LIVE : ST_COUNT;
                end
            end
            ST_COUNT:  if (last_col) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_GEN;
            ST_GEN:    if (last_col) state_next = ST_DONE;
            ST_LIVE:   if (last_col) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.ready      = 1'b1;
                ctl.load_frame = in_valid && (in_cmd == CMD_LOAD);
                ctl.step_start = in_valid && (in_cmd == CMD_STEP);
                ctl.acc_clr    = in_valid;
            end
            ST_COUNT:  ctl.count_en = 1'b1;
            ST_DECIDE:
            begin
                ctl.decide  = 1'b1;
                ctl.acc_clr = 1'b1;
            end
            ST_GEN:    ctl.gen_en = 1'b1;
            ST_LIVE:   ctl.live_en = 1'b1;
            ST_DONE:   ctl.out_load = out_free;
            default:   ctl = '0;
        endcase
    end

    // column counter runs during scans
    always_comb
    begin
        if (state_reg == ST_COUNT || state_reg == ST_GEN || state_reg == ST_LIVE)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // the counter is at rest outside the scans
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE || state_reg == ST_DECIDE)
        |-> cnt_reg == '0)
        else $error("column counter not at rest");

    // a count scan always ends in the decision cycle
    a_count_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT && last_col) |=> state_reg == ST_DECIDE)
        else $error("count scan did not reach decision");

    // a count scan visits every column once, after the accepting cycle
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> $past(state_reg, COLUMNS + 1) == ST_IDLE)
        else $error("count scan length wrong");
`endif

endmodule

FILE: rtl/life_automaton_torus_16x8.sv
// Top level: Life B3/S23 on a 16x8 torus with pending and shown frames.
// A step word runs a count scan, the decision state and a generation scan;
// a load word runs a population scan. Each scan goes column by column
// through the shared population unit, and no new word is taken until
// the result is in the output register; ready returns as soon as it is.
// Reset (rst_n low, asynchronous) clears both frames, all counters, and
// returns the configuration registers to their defaults.
module life_automaton_torus_16x8
    import lfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [63:0] frame_low, [127:64] frame_high, [191:128] random_bits
    input  logic [191:0]          s_tdata,
    // [0] cmd
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [63:0] shown_low, [127:64] shown_high, [128] was_cleared,
    // [129] was_reseeded, [137:130] live_cells, [143:138] zero
    output logic [143:0]          m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_t ctl;

    // configuration
    logic [7:0] dead_limit_reg;
    logic [7:0] same_limit_reg;
    logic [7:0] stable_limit_reg;
    logic [9:0] cycle_limit_reg;
    logic [7:0] seed_mask_reg;

    // frames and detection state
    frame_t shown_reg,   shown_next;
    frame_t pending_reg, pending_next;
    logic [CNT_W-1:0] dead_reg,   dead_next;
    logic [CNT_W-1:0] same_reg,   same_next;
    logic [CNT_W-1:0] stable_reg, stable_next;
    logic [CNT_W-1:0] cycle_reg,  cycle_next;
    logic             any_live_reg, any_live_next;
    logic             differ_reg,   differ_next;
    logic             cleared_reg,  cleared_next;
    logic             reseeded_reg, reseeded_next;
    logic [63:0]      rand_reg;

    // output register
    logic         m_valid_reg, m_valid_next;
    logic [143:0] m_data_reg;

    // shared units
    col_t                    new_col;
    col_t                    pop_a;
    col_t                    pop_b;
    logic signed [ACC_W-1:0] acc;
    logic                    out_free;

    assign out_free = !m_valid_reg || m_tready;

    lfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser[0]),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // window at fixed taps of the rotating shown frame
    lfa_next_col u_next_col (
        .left     (shown_reg[COLUMNS-1]),
        .mid      (shown_reg[0]),
        .right    (shown_reg[1]),
        .next_col (new_col)
    );

    // population operands per scan
    always_comb
    begin
        pop_a = '0;
        pop_b = '0;
        if (ctl.count_en)
        begin
            pop_a = pending_reg[0];
            pop_b = shown_reg[0];
        end
        else if (ctl.gen_en)
        begin
            pop_a = new_col;
        end
        else if (ctl.live_en)
        begin
            pop_a = pending_reg[0];
        end
    end

    lfa_pop_acc u_pop_acc (
        .clk (clk),
        .clr (ctl.acc_clr),
        .en  (ctl.count_en || ctl.gen_en || ctl.live_en),
        .a   (pop_a),
        .b   (pop_b),
        .acc (acc)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_limit_reg   <= DEAD_LIMIT_RST;
            same_limit_reg   <= SAME_LIMIT_RST;
            stable_limit_reg <= STABLE_LIMIT_RST;
            cycle_limit_reg  <= CYCLE_LIMIT_RST;
            seed_mask_reg    <= SEED_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEAD_LIMIT:   dead_limit_reg   <= cfg_data[7:0];
                REG_SAME_LIMIT:   same_limit_reg   <= cfg_data[7:0];
                REG_STABLE_LIMIT: stable_limit_reg <= cfg_data[7:0];
                REG_CYCLE_LIMIT:  cycle_limit_reg  <= cfg_data[9:0];
                REG_SEED_MASK:    seed_mask_reg    <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // frame and counter datapath
    always_comb
    begin
        logic clr;
        logic rsd;
        shown_next    = shown_reg;
        pending_next  = pending_reg;
        dead_next     = dead_reg;
        same_next     = same_reg;
        stable_next   = stable_reg;
        cycle_next    = cycle_reg;
        any_live_next = any_live_reg;
        differ_next   = differ_reg;
        cleared_next  = cleared_reg;
        reseeded_next = reseeded_reg;
        clr = 1'b0;
        rsd = 1'b0;

        if (ctl.load_frame)
        begin
            for (int c = 0; c < COLUMNS / 2; c++)
            begin
                pending_next[c]               = s_tdata[8*c +: 8];
                pending_next[c + COLUMNS / 2] = s_tdata[64 + 8*c +: 8];
            end
            cleared_next  = 1'b0;
            reseeded_next = 1'b0;
        end
        else if (ctl.step_start)
        begin
            any_live_next = 1'b0;
            differ_next   = 1'b0;
        end
        else if (ctl.count_en || ctl.live_en)
        begin
            // rotate so column k sits at tap 0 on scan cycle k
            for (int c = 0; c < COLUMNS - 1; c++)
            begin
                pending_next[c] = pending_reg[c + 1];
            end
            pending_next[COLUMNS-1] = pending_reg[0];
            if (ctl.count_en)
            begin
                for (int c = 0; c < COLUMNS - 1; c++)
                begin
                    shown_next[c] = shown_reg[c + 1];
                end
                shown_next[COLUMNS-1] = shown_reg[0];
                any_live_next = any_live_reg || (pending_reg[0] != '0);
                differ_next   = differ_reg || (pending_reg[0] != shown_reg[0]);
            end
        end
        else if (ctl.decide)
        begin
            // detection counters
            if (!any_live_reg)
            begin
                dead_next = dead_reg + 1'b1;
            end
            else if (!differ_reg)
            begin
                same_next = same_reg + 1'b1;
            end
            else if (acc == '0)
            begin
                stable_next = stable_reg + 1'b1;
            end
            else
            begin
                dead_next   = '0;
                same_next   = '0;
                stable_next = '0;
            end
            cycle_next = cycle_reg + 1'b1;

            clr = (same_next > {8'd0, same_limit_reg})
               || (stable_next > {8'd0, stable_limit_reg})
               || (cycle_next > {6'd0, cycle_limit_reg});
            rsd = (dead_next >= {8'd0, dead_limit_reg});
            if (clr)
            begin
                cycle_next = '0;
            end

            // clear, reseed, then show
            for (int c = 0; c < COLUMNS; c++)
            begin
                if (rsd && c >= SEED_FIRST && c <= SEED_LAST)
                begin
                    pending_next[c] = rand_reg[8*(c - SEED_FIRST) +: 8] & seed_mask_reg;
                end
                else if (clr)
                begin
                    pending_next[c] = '0;
                end
            end
            shown_next    = pending_next;
            cleared_next  = clr;
            reseeded_next = rsd;
        end
        else if (ctl.gen_en)
        begin
            // shown rotates back to place; new columns shift in at the top
            for (int c = 0; c < COLUMNS - 1; c++)
            begin
                shown_next[c]   = shown_reg[c + 1];
                pending_next[c] = pending_reg[c + 1];
            end
            shown_next[COLUMNS-1]   = shown_reg[0];
            pending_next[COLUMNS-1] = new_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg    <= '0;
            pending_reg  <= '0;
            dead_reg     <= '0;
            same_reg     <= '0;
            stable_reg   <= '0;
            cycle_reg    <= '0;
            any_live_reg <= 1'b0;
            differ_reg   <= 1'b0;
            cleared_reg  <= 1'b0;
            reseeded_reg <= 1'b0;
        end
        else
        begin
            shown_reg    <= shown_next;
            pending_reg  <= pending_next;
            dead_reg     <= dead_next;
            same_reg     <= same_next;
            stable_reg   <= stable_next;
            cycle_reg    <= cycle_next;
            any_live_reg <= any_live_next;
            differ_reg   <= differ_next;
            cleared_reg  <= cleared_next;
            reseeded_reg <= reseeded_next;
        end
    end

    // seed bytes of the step word
    always_ff @(posedge clk)
    begin
        if (ctl.step_start)
        begin
            rand_reg <= s_tdata[191:128];
        end
    end

    // output word register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (ctl.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            m_data_reg <= {6'd0, acc[7:0], reseeded_reg, cleared_reg, shown_reg};
        end
    end

    assign s_tready = ctl.ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // a frame never holds more than the grid size
    a_live_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[137:130] <= 8'd128)
        else $error("live count above grid size");

    // clear plus reseed leaves only the seeded columns alive
    a_clr_rsd: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[128] && m_tdata[129])
        |-> (m_tdata[31:0] == 32'd0 && m_tdata[127:96] == 32'd0))
        else $error("cleared columns outside the seed area are live");

    // an accepted word blocks the input until its work is done
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after acceptance");
`endif

endmodule

FILE: verif/life_generation_checker.sv
// Checker for the Life torus: predicts each result word and compares it field by field.
module life_generation_checker
    import lfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // [63:0] frame_low, [127:64] frame_high, [191:128] random_bits
    input  logic [191:0]          s_tdata,
    // [0] cmd
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // [63:0] shown_low, [127:64] shown_high, [128] was_cleared,
    // [129] was_reseeded, [137:130] live_cells, [143:138] zero
    input  logic [143:0]          m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic [5:0] pad;
        logic [7:0] live;
        logic       reseeded;
        logic       cleared;
        frame_t     shown;
    } gen_word_t;

    // predicted block state
    frame_t      shown_f;
    frame_t      pending_f;
    logic [15:0] dead_cnt;
    logic [15:0] same_cnt;
    logic [15:0] stable_cnt;
    logic [15:0] cycle_cnt;

    // limit registers
    logic [7:0]  dead_lim;
    logic [7:0]  same_lim;
    logic [7:0]  stable_lim;
    logic [9:0]  cycle_lim;
    logic [7:0]  seed_mask;

    gen_word_t   expected_q[$];
    int          word_no = 0;
    int          fail_total = 0;

    assign mismatches = fail_total;

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("%0t result word %0d: %s is %h, expected %h", $time, word_no, field, got, want);
        fail_total++;
    endtask

    // apply one input word to the predicted state and return the expected result
    task automatic advance_generation(input logic cmd, input frame_t loaded,
                                      input logic [63:0] seeds, output gen_word_t want);
        int     pop_p;
        int     pop_s;
        int     x;
        int     y;
        int     dx;
        int     dy;
        int     nb;
        frame_t nxt;

        want = '0;
        if (cmd == CMD_LOAD)
        begin
            pending_f = loaded;
        end
        else
        begin
            pop_p = $countones(pending_f);
            pop_s = $countones(shown_f);

            // dead / identical / stable detection
            if (pop_p == 0)
                dead_cnt++;
            else if (pending_f == shown_f)
                same_cnt++;
            else if (pop_p == pop_s)
                stable_cnt++;
            else
            begin
                dead_cnt   = '0;
                same_cnt   = '0;
                stable_cnt = '0;
            end
            cycle_cnt++;

            // clear; dead_cnt is left alone
            if (same_cnt > same_lim || stable_cnt > stable_lim || cycle_cnt > cycle_lim)
            begin
                pending_f    = '0;
                cycle_cnt    = '0;
                want.cleared = 1'b1;
            end

            // reseed the middle columns
            if (dead_cnt >= dead_lim)
            begin
                for (x = 0; x < 8; x++)
                    pending_f[SEED_FIRST + x] = seeds[8*x +: 8] & seed_mask;
                want.reseeded = 1'b1;
            end

            shown_f = pending_f;

            // B3/S23 with wraparound on both axes
            for (x = 0; x < COLUMNS; x++)
            begin
                for (y = 0; y < ROWS; y++)
                begin
                    nb = 0;
                    for (dx = 0; dx < 3; dx++)
                        for (dy = 0; dy < 3; dy++)
                            if (dx != 1 || dy != 1)
                                nb += int'(shown_f[(x + dx + COLUMNS - 1) % COLUMNS]
                                                  [(y + dy + ROWS - 1) % ROWS]);
                    nxt[x][y] = (nb == 3) || (nb == 2 && shown_f[x][y]);
                end
            end
            pending_f = nxt;
        end
        want.shown = shown_f;
        want.live  = 8'($countones(pending_f));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gen_word_t got;
        gen_word_t want;

        if (!rst_n)
        begin
            shown_f    = '0;
            pending_f  = '0;
            dead_cnt   = '0;
            same_cnt   = '0;
            stable_cnt = '0;
            cycle_cnt  = '0;
            dead_lim   = DEAD_LIMIT_RST;
            same_lim   = SAME_LIMIT_RST;
            stable_lim = STABLE_LIMIT_RST;
            cycle_lim  = CYCLE_LIMIT_RST;
            seed_mask  = SEED_MASK_RST;
            expected_q.delete();
            words_in_flight <= 0;
        end
        else
        begin
            // register writes; unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEAD_LIMIT:   dead_lim   = cfg_data[7:0];
                    REG_SAME_LIMIT:   same_lim   = cfg_data[7:0];
                    REG_STABLE_LIMIT: stable_lim = cfg_data[7:0];
                    REG_CYCLE_LIMIT:  cycle_lim  = cfg_data;
                    REG_SEED_MASK:    seed_mask  = cfg_data[7:0];
                    default:          ;
                endcase
            end

            // result side
            if (m_tvalid && m_tready)
            begin
                got = gen_word_t'(m_tdata);
                if (expected_q.size() == 0)
                begin
                    report("word with nothing expected, shown_low", got.shown[7:0], '0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.shown[7:0] !== want.shown[7:0])
                        report("shown_low", got.shown[7:0], want.shown[7:0]);
                    if (got.shown[15:8] !== want.shown[15:8])
                        report("shown_high", got.shown[15:8], want.shown[15:8]);
                    if (got.cleared !== want.cleared)
                        report("was_cleared", 64'(got.cleared), 64'(want.cleared));
                    if (got.reseeded !== want.reseeded)
                        report("was_reseeded", 64'(got.reseeded), 64'(want.reseeded));
                    if (got.live !== want.live)
                        report("live_cells", 64'(got.live), 64'(want.live));
                    if (got.pad !== want.pad)
                        report("pad bits", 64'(got.pad), 64'(want.pad));
                end
                word_no++;
            end

            // input side
            if (s_tvalid && s_tready)
            begin
                advance_generation(s_tuser[0], frame_t'(s_tdata[127:0]), s_tdata[191:128], want);
                expected_q.push_back(want);
            end

            words_in_flight <= expected_q.size();
        end
    end

endmodule

FILE: verif/tb_life_automaton_torus_16x8.sv
// Testbench top for the Life torus: clock, reset, stimulus, register writes and verdict.
module tb_life_automaton_torus_16x8;
    timeunit 1ns;
    timeprecision 1ps;
    import lfa_pkg::*;

    localparam int RUN_LIMIT = 600000;

    // 3x3 shapes, bit dy*3+dx
    localparam logic [8:0] GLIDER      = 9'b111_100_010;
    localparam logic [8:0] BLINKER     = 9'b000_111_000;
    localparam logic [8:0] STILL_BLOCK = 9'b000_011_011;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // [63:0] frame_low, [127:64] frame_high, [191:128] random_bits
    logic [191:0]          s_tdata;
    // [0] cmd
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // [63:0] shown_low, [127:64] shown_high, [128] was_cleared,
    // [129] was_reseeded, [137:130] live_cells, [143:138] zero
    logic [143:0]          m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int words_in_flight;
    int cycles = 0;
    int tx_odds = 0;      // sender gap odds, 0 = no gaps
    int rx_odds = 0;      // receiver stall odds, 0 = no stalls
    bit calm = 1'b0;      // closing stretch without sender gaps or receiver stalls

    life_automaton_torus_16x8 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    life_generation_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .words_in_flight (words_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("tb_life_automaton_torus_16x8 NOT OK");
            $finish;
        end
    end

    // result side back-pressure in bursts
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_odds != 0 && $urandom_range(0, rx_odds) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] sparse64();
        return rand64() & rand64() & rand64();
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 10;
        endcase
    endfunction

    // OR a 3x3 shape into the frame at (ox, oy), wrapping at the edges
    function automatic frame_t stamp(input frame_t base, input logic [8:0] shape,
                                     input int ox, input int oy);
        frame_t f;
        int     dx;
        int     dy;

        f = base;
        for (dy = 0; dy < 3; dy++)
            for (dx = 0; dx < 3; dx++)
                if (shape[dy*3 + dx])
                    f[(ox + dx) % COLUMNS][(oy + dy) % ROWS] = 1'b1;
        return f;
    endfunction

    function automatic frame_t random_pattern();
        frame_t f;
        int     k;

        case ($urandom_range(0, 9))
            0:       f = '0;
            1:       f = '1;
            2, 3:    f = {rand64(), rand64()};
            4, 5:    f = {sparse64(), sparse64()};
            default:
            begin
                f = '0;
                if ($urandom_range(0, 1))
                    f = {sparse64() & rand64(), sparse64() & rand64()};
                repeat ($urandom_range(1, 3))
                begin
                    k = $urandom_range(0, 2);
                    f = stamp(f, (k == 0) ? GLIDER : (k == 1) ? BLINKER : STILL_BLOCK,
                              $urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1));
                end
            end
        endcase
        return f;
    endfunction

    function automatic logic [63:0] seed_bytes();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    // hand one word to the block, with an optional gap before it
    task automatic push_word(input logic cmd, input frame_t frame, input logic [63:0] seeds);
        if (tx_odds != 0 && $urandom_range(0, tx_odds) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {seeds, frame};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic load_word(input frame_t frame);
        push_word(CMD_LOAD, frame, rand64());
    endtask

    task automatic step_word(input logic [63:0] seeds);
        push_word(CMD_STEP, {rand64(), rand64()}, seeds);
    endtask

    // drop valid and hold off until every expected word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // 8-bit registers get random junk in the unused upper bits
    task automatic program_limits(input logic [7:0] dl, input logic [7:0] sl,
                                  input logic [7:0] stl, input logic [9:0] cl,
                                  input logic [7:0] mask);
        write_reg(REG_DEAD_LIMIT,   {2'($urandom), dl});
        write_reg(REG_SAME_LIMIT,   {2'($urandom), sl});
        write_reg(REG_STABLE_LIMIT, {2'($urandom), stl});
        write_reg(REG_CYCLE_LIMIT,  cl);
        write_reg(REG_SEED_MASK,    {2'($urandom), mask});
    endtask

    // random part: mostly a load followed by a run of generation steps
    task automatic run_phase(input int words);
        int sent;
        int run;

        sent = 0;
        while (sent < words)
        begin
            tx_odds = calm ? 0 : pick_odds();
            rx_odds = calm ? 0 : pick_odds();
            if ($urandom_range(0, 4) != 0)
            begin
                load_word(random_pattern());
                sent++;
            end
            run = $urandom_range(1, 40);
            repeat (run) step_word(seed_bytes());
            sent += run;
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty grid from reset: the fourth step reseeds
        repeat (3) step_word(rand64());
        step_word('1);
        // full grid dies off
        load_word('1);
        step_word(rand64());
        step_word(rand64());
        load_word('0);
        step_word(rand64());
        // still life: identical frames
        load_word(stamp('0, STILL_BLOCK, 7, 3));
        repeat (3) step_word(rand64());
        // oscillator: equal population
        load_word(stamp('0, BLINKER, 0, 0));
        repeat (3) step_word(rand64());
        // glider across both wrap edges
        load_word(stamp('0, GLIDER, COLUMNS - 2, ROWS - 2));
        repeat (3) step_word(rand64());
        load_word({rand64(), rand64()});
        step_word(rand64());
        wait_drained();

        // writes to unknown indexes must be ignored
        for (int i = int'(REG_SEED_MASK) + 1; i < 2**CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        // zero dead limit: reseed on every step
        write_reg(REG_DEAD_LIMIT, '0);
        step_word('1);
        step_word(rand64());
        wait_drained();

        // tightest limits
        program_limits(8'd1, 8'd0, 8'd0, 10'd0, 8'hFF);
        run_phase(200);
        wait_drained();

        // loosest limits
        program_limits(8'd255, 8'd255, 8'd255, 10'd1023, 8'hFF);
        run_phase(220);
        wait_drained();

        // zero dead limit with random others
        program_limits(8'd0, 8'($urandom_range(0, 12)), 8'($urandom_range(0, 50)),
                       10'($urandom_range(0, 1023)), 8'($urandom));
        run_phase(180);
        wait_drained();

        repeat (3)
        begin
            program_limits(8'($urandom_range(1, 10)), 8'($urandom_range(0, 12)),
                           8'($urandom_range(0, 50)), 10'($urandom_range(0, 300)),
                           8'($urandom));
            run_phase(200);
            wait_drained();
        end

        // closing stretch at reset values, no sender gaps or receiver stalls
        calm = 1'b1;
        program_limits(DEAD_LIMIT_RST, SAME_LIMIT_RST, STABLE_LIMIT_RST, CYCLE_LIMIT_RST,
                       SEED_MASK_RST);
        run_phase(200);
        wait_drained();
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("tb_life_automaton_torus_16x8 OK");
        else
            $display("tb_life_automaton_torus_16x8 NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/lfa_pkg.sv
rtl/lfa_next_col.sv
rtl/lfa_pop_acc.sv
rtl/lfa_ctrl.sv
rtl/life_automaton_torus_16x8.sv
verif/life_generation_checker.sv
verif/tb_life_automaton_torus_16x8.sv
